// ===== design/risd_pkg.sv =====
// Shared types and constants of the record ranking core.
package risd_pkg;

  // Default capacity of the cell chain.
  localparam int MaxRecordsDefault = 64;
  // Counter width that covers any capacity up to 64 records.
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0] record_tag;
    logic [31:0] deaths_total;
    logic [31:0] cases_total;
    logic        last_record;
  } item_t;

  typedef struct packed {
    logic [15:0] ranked_tag;
    logic [31:0] ranked_deaths;
    logic [31:0] ranked_cases;
    logic        final_result;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] deaths;
    logic [31:0] cases;
  } rec_t;

  typedef struct packed {
    logic             load_en;
    logic             sort_en;
    logic             shift_en;
    logic             parity;
    logic             key_sel;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] count;
  } ctrl_t;

endpackage

// ===== design/risd_cell.sv =====
// One cell of the ranking chain: holds a record, swaps or shifts with its neighbours.
module risd_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  risd_pkg::ctrl_t ctrl,
  input  risd_pkg::rec_t load_rec,
  input  risd_pkg::rec_t down_rec,
  input  logic           down_swap,
  input  risd_pkg::rec_t up_rec,
  output risd_pkg::rec_t rec,
  output logic           swap
);

  localparam logic ODD = 1'(IDX % 2);

  risd_pkg::rec_t rec_next;
  logic           pair_act;
  logic [31:0]    key_self;
  logic [31:0]    key_up;

  // This cell leads the pair (IDX, IDX+1) on rounds of matching parity.
  assign pair_act = ctrl.sort_en && (ctrl.parity == ODD) &&
                    (risd_pkg::CNT_W'(IDX + 1) < ctrl.count);
  assign key_self = ctrl.key_sel ? rec.cases : rec.deaths;
  assign key_up   = ctrl.key_sel ? up_rec.cases : up_rec.deaths;
  // Strictly smaller only, so equal keys keep arrival order.
  assign swap     = pair_act && (key_self < key_up);

  always_comb begin
    rec_next = rec;
    if (ctrl.load_en && (ctrl.wr_idx == risd_pkg::CNT_W'(IDX))) begin
      rec_next = load_rec;
    end else if (ctrl.shift_en) begin
      rec_next = up_rec;
    end else if (swap) begin
      rec_next = up_rec;
    end else if (down_swap) begin
      rec_next = down_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// ===== design/record_insertion_sort_descending_core.sv =====
// Record ranking core: collects records in a chain of cells, ranks and streams them out.
// A record without the last mark leaves busy low, so such records may come on every cycle.
// A record with the last mark raises busy: the chain then runs n odd-even transposition
// rounds, one per cycle (n = records held), after which the records leave cell 0 one per
// cycle, and busy falls as the final result is registered. The receiver cannot stall:
// each result is shown with result_strobe high for exactly one cycle. Ties keep arrival
// order; records beyond capacity are dropped and flagged by overflow.
module record_insertion_sort_descending_core #(
  parameter int MAX_RECORDS = risd_pkg::MaxRecordsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  risd_pkg::item_t   item,
  output logic              result_strobe,
  output risd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int CW = risd_pkg::CNT_W;

  risd_pkg::state_t state;
  risd_pkg::state_t state_next;

  logic           sort_key;
  logic [CW-1:0]  count;
  logic           dropped;
  logic [CW-1:0]  set_n;
  logic           set_ovf;
  logic [CW-1:0]  round;
  logic [CW-1:0]  remaining;

  logic           accept;
  logic           has_room;
  logic           sort_en;
  logic           shift_en;
  risd_pkg::ctrl_t ctrl;
  risd_pkg::rec_t  in_rec;
  risd_pkg::rec_t  cell_rec  [MAX_RECORDS];
  logic            cell_swap [MAX_RECORDS];

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign has_room  = count < CW'(MAX_RECORDS);

  assign in_rec.tag    = item.record_tag;
  assign in_rec.deaths = item.deaths_total;
  assign in_rec.cases  = item.cases_total;

  assign ctrl.load_en  = accept && has_room;
  assign ctrl.sort_en  = sort_en;
  assign ctrl.shift_en = shift_en;
  assign ctrl.parity   = round[0];
  assign ctrl.key_sel  = sort_key;
  assign ctrl.wr_idx   = count;
  assign ctrl.count    = set_n;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      risd_pkg::ST_IDLE: begin
        if (accept && item.last_record) state_next = risd_pkg::ST_SORT;
      end
      risd_pkg::ST_SORT: begin
        if (round == set_n - CW'(1)) state_next = risd_pkg::ST_EMIT;
      end
      risd_pkg::ST_EMIT: begin
        if (remaining == CW'(1)) state_next = risd_pkg::ST_IDLE;
      end
      default: state_next = risd_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy     = 1'b0;
    sort_en  = 1'b0;
    shift_en = 1'b0;
    unique case (state)
      risd_pkg::ST_IDLE: ;
      risd_pkg::ST_SORT: begin
        busy    = 1'b1;
        sort_en = 1'b1;
      end
      risd_pkg::ST_EMIT: begin
        busy     = 1'b1;
        shift_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= risd_pkg::ST_IDLE;
      sort_key      <= 1'b0;
      count         <= '0;
      dropped       <= 1'b0;
      set_n         <= '0;
      set_ovf       <= 1'b0;
      round         <= '0;
      remaining     <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= shift_en;
      if (cfg_valid && cfg_ready) sort_key <= cfg_data;
      if (accept) begin
        if (item.last_record) begin
          // Close the set: hand its size and drop flag to the sort and emit phases.
          set_n   <= has_room ? count + CW'(1) : count;
          set_ovf <= dropped || !has_room;
          count   <= '0;
          dropped <= 1'b0;
          round   <= '0;
        end else if (has_room) begin
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (sort_en) begin
        round <= round + CW'(1);
        if (state_next == risd_pkg::ST_EMIT) remaining <= set_n;
      end
      if (shift_en) remaining <= remaining - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      result.ranked_tag    <= cell_rec[0].tag;
      result.ranked_deaths <= cell_rec[0].deaths;
      result.ranked_cases  <= cell_rec[0].cases;
      result.final_result  <= (remaining == CW'(1));
      result.overflow      <= set_ovf;
    end
  end

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    risd_pkg::rec_t down_rec;
    risd_pkg::rec_t up_rec;
    logic           down_swap;

    if (i == 0) begin : g_head
      assign down_rec  = '0;
      assign down_swap = 1'b0;
    end else begin : g_body
      assign down_rec  = cell_rec[i-1];
      assign down_swap = cell_swap[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign up_rec = cell_rec[i];
    end else begin : g_link
      assign up_rec = cell_rec[i+1];
    end

    risd_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_rec (in_rec),
      .down_rec (down_rec),
      .down_swap(down_swap),
      .up_rec   (up_rec),
      .rec      (cell_rec[i]),
      .swap     (cell_swap[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_plain_record_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last_record) |=> !busy)
    else $error("busy raised by a record without the last mark");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == risd_pkg::ST_EMIT))
    else $error("result strobe outside the emit phase");

  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.final_result) |-> (state == risd_pkg::ST_IDLE))
    else $error("final result while the core is still busy");

endmodule
